// ===== hdl/frt_pkg.sv =====
// Types and constants shared by the fault region table.
// No dependencies.
package frt_pkg;

   typedef enum logic [1:0] {
      ACT_DECLARE = 2'd0,
      ACT_MARK    = 2'd1,
      ACT_RESOLVE = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_INVALID     = 3'd1,
      ST_OVERLAP     = 3'd2,
      ST_EXHAUSTED   = 3'd3,
      ST_NOT_FOUND   = 3'd4,
      ST_WRONG_STATE = 3'd5
   } status_type;

   localparam logic [1:0] BK_UNBACKED = 2'd0;
   localparam logic [1:0] BK_SHARED   = 2'd1;
   localparam logic [1:0] BK_PRIVATE  = 2'd2;
   localparam logic [1:0] BK_UNDEF    = 2'd3;

   localparam logic [15:0] ID_FIRST = 16'd1;
   localparam logic [15:0] ID_LIMIT = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] address;
      logic [63:0] span_bytes;
      logic        sealed;
      logic [1:0]  backing_kind;
      logic [15:0] region_id;
      logic        is_write;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] result_id;
      logic        deliver;
      logic        write_echo;
      logic [1:0]  state_out;
   } rsp_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic        hit;
      logic        free;
      logic        overlap;
      logic [15:0] id;
      logic        sealed;
      logic [1:0]  backing;
      logic        told_backing;
      logic        told_private;
   } probe_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_DECLARE,
      CMD_BACKING,
      CMD_TOLD_BACKING,
      CMD_TOLD_PRIVATE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [15:0] id;
      logic        sealed;
      logic [1:0]  backing;
   } cmd_type;

endpackage

// ===== hdl/fault_region_table_top.sv =====
// Top level of the fault region table: sequencer and the chain of entry cells.
// Depends on frt_pkg and frt_cell.
//
// Each item passes through three steps: accept, a scan while the token walks
// the cell chain, registered once in every cell, and a decide step that updates
// the chosen entry. busy is high from the cycle after acceptance through the
// decide step, so no new item is taken meanwhile. The result is
// on the ports for a single cycle with rsp_strobe, the first cycle with busy
// low again; the receiver cannot stall it, and a new item may start in that cycle.
module fault_region_table_top import frt_pkg::*; #(
   parameter int NUM_ENTRIES = 16,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int PW = 64 - PAGE_SHIFT;
   localparam int EW = PW + 1;
   localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] count_ff, count_in;
   logic [1:0]    act_ff, act_in;
   logic [PW-1:0] page_ff, page_in;
   logic [EW-1:0] end_ff, end_in;
   logic [15:0]   id_ff, id_in;
   logic [1:0]    kind_ff, kind_in;
   logic          seal_ff, seal_in;
   logic          wr_ff, wr_in;
   logic          inval_ff, inval_in;
   logic [15:0]   next_id_ff, next_id_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   probe_type     probe_chain [0:NUM_ENTRIES];
   logic [IW-1:0] hidx_chain  [0:NUM_ENTRIES];
   logic [IW-1:0] fidx_chain  [0:NUM_ENTRIES];
   cmd_type       cmd;
   logic [IW-1:0] cmd_idx;
   probe_type     pr;

   assign probe_chain[0] = '0;
   assign hidx_chain[0]  = '0;
   assign fidx_chain[0]  = '0;

   for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
      frt_cell #(.PW(PW), .EW(EW), .IW(IW), .IDX(g)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .op_page      (page_ff),
         .op_end       (end_ff),
         .op_id        (id_ff),
         .op_addr_mode (act_ff == ACT_RESOLVE),
         .probe_in     (probe_chain[g]),
         .hit_idx_in   (hidx_chain[g]),
         .free_idx_in  (fidx_chain[g]),
         .probe_out    (probe_chain[g+1]),
         .hit_idx_out  (hidx_chain[g+1]),
         .free_idx_out (fidx_chain[g+1]),
         .cmd          (cmd),
         .cmd_idx      (cmd_idx)
      );
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      act_in     = act_ff;
      page_in    = page_ff;
      end_in     = end_ff;
      id_in      = id_ff;
      kind_in    = kind_ff;
      seal_in    = seal_ff;
      wr_in      = wr_ff;
      inval_in   = inval_ff;
      next_id_in = next_id_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      cmd        = '{op: CMD_NONE, id: next_id_ff, sealed: seal_ff, backing: kind_ff};
      cmd_idx    = hidx_chain[NUM_ENTRIES];
      pr         = probe_chain[NUM_ENTRIES];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               count_in = '0;
               act_in   = req_item.action;
               page_in  = PW'(req_item.address >> PAGE_SHIFT);
               end_in   = EW'(req_item.address >> PAGE_SHIFT) +
                          EW'(req_item.span_bytes >> PAGE_SHIFT);
               id_in    = req_item.region_id;
               kind_in  = req_item.backing_kind;
               seal_in  = req_item.sealed;
               wr_in    = req_item.is_write;
               inval_in = (req_item.span_bytes == 64'd0) ||
                          ((req_item.address & PAGE_MASK) != 64'd0) ||
                          ((req_item.span_bytes & PAGE_MASK) != 64'd0) ||
                          (req_item.address > ~req_item.span_bytes);
            end
         end
         S_SCAN: begin
            count_in = count_ff + IW'(1);
            if (count_ff == IW'(NUM_ENTRIES - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            rsp_in    = '{status: ST_OK, result_id: 16'd0, deliver: 1'b0,
                          write_echo: 1'b0, state_out: 2'd0};
            unique case (act_ff)
               ACT_DECLARE: begin
                  if (inval_ff) begin
                     rsp_in.status = ST_INVALID;
                  end else if (pr.overlap) begin
                     rsp_in.status = ST_OVERLAP;
                  end else if (next_id_ff == ID_LIMIT || !pr.free) begin
                     rsp_in.status = ST_EXHAUSTED;
                  end else begin
                     rsp_in.result_id = next_id_ff;
                     cmd.op           = CMD_DECLARE;
                     cmd_idx          = fidx_chain[NUM_ENTRIES];
                     next_id_in       = next_id_ff + 16'd1;
                  end
               end
               ACT_MARK: begin
                  if (id_ff == 16'd0 || !pr.hit) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else if (kind_ff == BK_UNBACKED || kind_ff == BK_UNDEF) begin
                     rsp_in.status = ST_WRONG_STATE;
                  end else begin
                     cmd.op = CMD_BACKING;
                  end
               end
               ACT_RESOLVE: begin
                  rsp_in.write_echo = wr_ff;
                  if (pr.hit && !pr.sealed) begin
                     if (pr.backing == BK_UNBACKED) begin
                        if (!pr.told_backing) begin
                           rsp_in.deliver   = 1'b1;
                           rsp_in.result_id = pr.id;
                           cmd.op           = CMD_TOLD_BACKING;
                        end
                     end else if (wr_ff && pr.backing == BK_SHARED && !pr.told_private) begin
                        rsp_in.deliver   = 1'b1;
                        rsp_in.result_id = pr.id;
                        cmd.op           = CMD_TOLD_PRIVATE;
                     end
                  end
               end
               ACT_QUERY: begin
                  if (id_ff == 16'd0 || !pr.hit) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     rsp_in.state_out = pr.backing;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      page_ff  <= page_in;
      end_ff   <= end_in;
      id_ff    <= id_in;
      kind_ff  <= kind_in;
      seal_ff  <= seal_in;
      wr_ff    <= wr_in;
      inval_ff <= inval_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         next_id_ff <= ID_FIRST;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         next_id_ff <= next_id_in;
         strobe_ff  <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== hdl/frt_cell.sv =====
// One table entry with its compare logic and a stage of the scan token.
// Depends on frt_pkg.
module frt_cell import frt_pkg::*; #(
   parameter int PW  = 52,
   parameter int EW  = 53,
   parameter int IW  = 4,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [PW-1:0] op_page,
   input  logic [EW-1:0] op_end,
   input  logic [15:0]   op_id,
   input  logic          op_addr_mode,
   input  probe_type     probe_in,
   input  logic [IW-1:0] hit_idx_in,
   input  logic [IW-1:0] free_idx_in,
   output probe_type     probe_out,
   output logic [IW-1:0] hit_idx_out,
   output logic [IW-1:0] free_idx_out,
   input  cmd_type       cmd,
   input  logic [IW-1:0] cmd_idx
);

   logic          valid_ff;
   logic [PW-1:0] base_ff;
   logic [EW-1:0] end_ff;
   logic [15:0]   id_ff;
   logic          sealed_ff;
   logic [1:0]    backing_ff;
   logic          told_b_ff;
   logic          told_p_ff;

   probe_type     probe_ff, probe_in_w;
   logic [IW-1:0] hit_idx_ff, hit_idx_in_w;
   logic [IW-1:0] free_idx_ff, free_idx_in_w;

   logic match_addr, match_id, overlap, sel;

   always_comb begin
      match_addr = valid_ff && ({1'b0, op_page} >= {1'b0, base_ff}) &&
                   (EW'(op_page) < end_ff);
      match_id   = valid_ff && (id_ff == op_id);
      overlap    = valid_ff && (EW'(base_ff) < op_end) && (EW'(op_page) < end_ff);
      probe_in_w    = probe_in;
      hit_idx_in_w  = hit_idx_in;
      free_idx_in_w = free_idx_in;
      probe_in_w.overlap = probe_in.overlap | overlap;
      if (!probe_in.hit && (op_addr_mode ? match_addr : match_id)) begin
         probe_in_w.hit          = 1'b1;
         probe_in_w.id           = id_ff;
         probe_in_w.sealed       = sealed_ff;
         probe_in_w.backing      = backing_ff;
         probe_in_w.told_backing = told_b_ff;
         probe_in_w.told_private = told_p_ff;
         hit_idx_in_w            = IW'(IDX);
      end
      if (!probe_in.free && !valid_ff) begin
         probe_in_w.free = 1'b1;
         free_idx_in_w   = IW'(IDX);
      end
      sel = (cmd_idx == IW'(IDX));
   end

   always_ff @(posedge clock) begin
      probe_ff    <= probe_in_w;
      hit_idx_ff  <= hit_idx_in_w;
      free_idx_ff <= free_idx_in_w;
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         case (cmd.op)
            CMD_DECLARE: begin
               valid_ff   <= 1'b1;
               base_ff    <= op_page;
               end_ff     <= op_end;
               id_ff      <= cmd.id;
               sealed_ff  <= cmd.sealed;
               backing_ff <= BK_UNBACKED;
               told_b_ff  <= 1'b0;
               told_p_ff  <= 1'b0;
            end
            CMD_BACKING:      backing_ff <= cmd.backing;
            CMD_TOLD_BACKING: told_b_ff  <= 1'b1;
            CMD_TOLD_PRIVATE: told_p_ff  <= 1'b1;
            default: ;
         endcase
      end
   end

   assign probe_out    = probe_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule
